/* hdl/xrg_pkg.sv */
// Shared types and constants of the xoshiro256++ random word generator.
package xrg_pkg;

    // One 64-bit state or output word, and one 32-bit multiplier operand.
    typedef logic [63:0] t_word;
    typedef logic [31:0] t_half;

    // Request to the shared multiplier: start pulse and the two operands.
    typedef struct packed {
        logic  start;
        t_word a;
        t_word b;
    } t_mul_req;

    // Command codes carried on the input tuser bit.
    localparam logic CMD_SEED = 1'b0;
    localparam logic CMD_NEXT = 1'b1;

    // Splitmix64 constants.
    localparam t_word GOLDEN_STEP = 64'h9E3779B97F4A7C15;
    localparam t_word MIX_MUL_A   = 64'hBF58476D1CE4E5B9;
    localparam t_word MIX_MUL_B   = 64'h94D049BB133111EB;

    // Shift and rotate amounts.
    localparam int ROT_OUT   = 23;
    localparam int SHL_S1    = 17;
    localparam int ROT_S3    = 45;
    localparam int MIX_SHR_A = 30;
    localparam int MIX_SHR_B = 27;
    localparam int MIX_SHR_C = 31;

endpackage

/* hdl/xoshiro256pp_random_generator.sv */
// Top level of the xoshiro256++ random word generator with splitmix64 seeding.
//
//   Channel  Direction  Signals                      Contents
//   s        in         i_s_tvalid/o_s_tready        tuser: command, tdata: seed_value
//   m        out        o_m_tvalid/i_m_tready        tdata: random_word
//
// A next request passes through a sum step, then an output and state update step;
// a new request is only taken once the generator is back in its idle state.
// A seed request produces four splitmix64 words, each needing
// two 64-bit products from the shared 32x32 multiplier.
// Synchronous active-low reset clears the state words to zero.
// A stalled output holds a next request in its update step until the word is taken.
module xoshiro256pp_random_generator import xrg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [63:0] seed_value
    input  logic        i_s_tuser,   // [0] command
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata    // [63:0] random_word
);

    typedef enum logic [4:0] {
        S_IDLE       = 5'b00001,
        S_NEXT_SUM   = 5'b00010,
        S_NEXT_UPD   = 5'b00100,
        S_SEED_MUL_A = 5'b01000,
        S_SEED_MUL_B = 5'b10000
    } t_state;

    t_state     r_state;
    t_state     n_state;
    t_word      r_gen_state [4];
    t_word      r_seed_acc;
    t_word      r_sum;
    t_word      r_out_data;
    logic       r_out_valid;
    logic [1:0] r_word;
    logic       w_in_acc;
    logic       w_out_free;
    logic       w_mul_done;
    t_word      w_product;
    t_word      w_seed_next;
    t_word      w_mix_a;
    t_word      w_mix_b;
    t_word      w_mix_c;
    t_word      w_rot_sum;
    t_word      w_word;
    t_word      w_s2;
    t_word      w_s3;
    t_word      w_s1;
    t_word      w_s0;
    t_mul_req   w_mul_req;

    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    // Splitmix64 mixing around the shared multiplier.
    assign w_seed_next = (r_state == S_IDLE) ? i_s_tdata + GOLDEN_STEP
                                             : r_seed_acc + GOLDEN_STEP;
    assign w_mix_a     = w_seed_next ^ (w_seed_next >> MIX_SHR_A);
    assign w_mix_b     = w_product ^ (w_product >> MIX_SHR_B);
    assign w_mix_c     = w_product ^ (w_product >> MIX_SHR_C);

    // Output word and xoshiro256++ state update.
    assign w_rot_sum = {r_sum[63-ROT_OUT:0], r_sum[63:64-ROT_OUT]};
    assign w_word    = w_rot_sum + r_gen_state[0];
    assign w_s2      = r_gen_state[2] ^ r_gen_state[0];
    assign w_s3      = r_gen_state[3] ^ r_gen_state[1];
    assign w_s1      = r_gen_state[1] ^ w_s2;
    assign w_s0      = r_gen_state[0] ^ w_s3;

    // Multiplier requests: first product starts on a seed request or after the
    // previous word is stored; the second starts when the first is done.
    always_comb begin
        w_mul_req.start = 1'b0;
        w_mul_req.a     = w_mix_a;
        w_mul_req.b     = MIX_MUL_A;
        if (r_state == S_SEED_MUL_A && w_mul_done) begin
            w_mul_req.start = 1'b1;
            w_mul_req.a     = w_mix_b;
            w_mul_req.b     = MIX_MUL_B;
        end else if ((w_in_acc && i_s_tuser == CMD_SEED) ||
                     (r_state == S_SEED_MUL_B && w_mul_done && r_word != 2'd3)) begin
            w_mul_req.start = 1'b1;
        end
    end

    xrg_mul64 u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_mul_req),
        .o_done    (w_mul_done),
        .o_product (w_product)
    );

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = (i_s_tuser == CMD_NEXT) ? S_NEXT_SUM : S_SEED_MUL_A;
                end
            end
            S_NEXT_SUM: n_state = S_NEXT_UPD;
            S_NEXT_UPD: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SEED_MUL_A: begin
                if (w_mul_done) begin
                    n_state = S_SEED_MUL_B;
                end
            end
            S_SEED_MUL_B: begin
                if (w_mul_done) begin
                    n_state = (r_word == 2'd3) ? S_IDLE : S_SEED_MUL_A;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_word      <= 2'd0;
        end else begin
            r_state <= n_state;
            if (r_state == S_NEXT_UPD && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_SEED_MUL_B && w_mul_done) begin
                r_word <= r_word + 2'd1;
            end
        end
    end

    // State words: cleared by reset, shifted in by seeding, updated by next.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_state[0] <= '0;
            r_gen_state[1] <= '0;
            r_gen_state[2] <= '0;
            r_gen_state[3] <= '0;
        end else if (r_state == S_SEED_MUL_B && w_mul_done) begin
            r_gen_state[0] <= r_gen_state[1];
            r_gen_state[1] <= r_gen_state[2];
            r_gen_state[2] <= r_gen_state[3];
            r_gen_state[3] <= w_mix_c;
        end else if (r_state == S_NEXT_UPD && w_out_free) begin
            r_gen_state[0] <= w_s0;
            r_gen_state[1] <= w_s1;
            r_gen_state[2] <= w_s2 ^ (r_gen_state[1] << SHL_S1);
            r_gen_state[3] <= {w_s3[63-ROT_S3:0], w_s3[63:64-ROT_S3]};
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_mul_req.start && r_state != S_SEED_MUL_A) begin
            r_seed_acc <= w_seed_next;
        end
        if (r_state == S_NEXT_SUM) begin
            r_sum <= r_gen_state[0] + r_gen_state[3];
        end
        if (r_state == S_NEXT_UPD && w_out_free) begin
            r_out_data <= w_word;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // A finished product only arrives while a seed is in progress.
    a_mul_done_in_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == S_SEED_MUL_A || r_state == S_SEED_MUL_B))
        else $error("multiplier result outside seeding");

    // A next request reaches the update step through the sum step after it is taken.
    a_next_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_s_tuser == CMD_NEXT) |=> ##1 (r_state == S_NEXT_UPD))
        else $error("next request did not reach update step");

    // Leaving the update step always presents a word.
    a_upd_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NEXT_UPD && w_out_free) |=> o_m_tvalid)
        else $error("update step did not present a word");

    // Seeding ends with the word counter wrapped back to zero.
    a_seed_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEED_MUL_B && w_mul_done && r_word == 2'd3)
            |=> (r_word == 2'd0 && r_state == S_IDLE))
        else $error("seed did not finish after four words");

endmodule

/* hdl/xrg_mul64.sv */
// Iterative 64x64 multiplier (low 64 bits of the product) on one 32x32 multiplier.
module xrg_mul64 import xrg_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output logic     o_done,
    output t_word    o_product
);

    // Partial product phases: low*low, low*high, high*low, then the last sum.
    localparam logic [1:0] PH_LO_LO = 2'd0;
    localparam logic [1:0] PH_LO_HI = 2'd1;
    localparam logic [1:0] PH_HI_LO = 2'd2;
    localparam logic [1:0] PH_SUM   = 2'd3;

    t_word      r_a;
    t_word      r_b;
    t_word      r_prod;
    t_word      r_acc;
    logic [1:0] r_phase;
    logic       r_busy;
    logic       r_done;
    t_half      w_op_x;
    t_half      w_op_y;
    t_word      w_mul;

    // Operand selection for the shared 32x32 multiplier.
    always_comb begin
        case (r_phase)
            PH_LO_LO: begin
                w_op_x = r_a[31:0];
                w_op_y = r_b[31:0];
            end
            PH_LO_HI: begin
                w_op_x = r_a[31:0];
                w_op_y = r_b[63:32];
            end
            default: begin
                w_op_x = r_a[63:32];
                w_op_y = r_b[31:0];
            end
        endcase
        w_mul = {32'd0, w_op_x} * {32'd0, w_op_y};
    end

    // Phase counter and completion flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= PH_LO_LO;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_phase <= PH_LO_LO;
            end else if (r_busy) begin
                r_phase <= r_phase + 2'd1;
                if (r_phase == PH_SUM) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand capture, registered partial product and accumulation.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
        end
        if (r_busy) begin
            r_prod <= w_mul;
            case (r_phase)
                PH_LO_LO: r_acc <= r_acc;
                PH_LO_HI: r_acc <= r_prod;
                default:  r_acc <= r_acc + {r_prod[31:0], 32'd0};
            endcase
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule
